### design/gfpa_pkg.sv
// ---------------------------------------------------------------------------
// gfpa_pkg: shared types for the GF(2) polynomial ALU
// Command codes, controller states and the control/status bundles.
// ---------------------------------------------------------------------------
package gfpa_pkg;

	localparam int MAX_DEG_DEF = 31;
	localparam int OPW = 32;
	localparam int PRW = 63;
	localparam int DEGW = 6; // signed degree, -1 marks the zero polynomial

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_MUL = 2'd1,
		OP_DIV = 2'd2,
		OP_GCD = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_EU,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_step;
		logic eu_step;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_last;
		logic eu_done;
	} dp_stat_t;

endpackage

### design/gf2_polynomial_alu_core.sv
// Add is finished at load; multiply takes one multiplier bit per cycle, MSB
// first; divide and gcd run the Euclid engine, which in each step either
// lowers one degree bound, does one shifted XOR, or swaps the pair.
// One word at a time; the next word is taken in the cycle after the result.
// Reset (arst_n low, asynchronous) returns the sequencer to idle.
// ---------------------------------------------------------------------------
// gf2_polynomial_alu_core: GF(2) polynomial ALU
// Add, carry-less multiply, divide with remainder, extended gcd.
// ---------------------------------------------------------------------------
module gf2_polynomial_alu_core #(
	parameter int MAX_DEG = gfpa_pkg::MAX_DEG_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] operand_x,
	input  logic [31:0] operand_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [62:0] primary,
	output logic [31:0] secondary,
	output logic [31:0] gcd_value,
	output logic        divide_by_zero
);

	gfpa_pkg::dp_cmd_t dcmd;
	gfpa_pkg::dp_stat_t dstat;

	gfpa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .out_valid(out_valid), .out_stall(out_stall),
		.dcmd(dcmd), .dstat(dstat)
	);

	gfpa_dp #(.MAX_DEG(MAX_DEG)) u_dp (
		.clk(clk), .cmd(cmd), .operand_x(operand_x), .operand_y(operand_y),
		.dcmd(dcmd), .dstat(dstat), .primary(primary), .secondary(secondary),
		.gcd_value(gcd_value), .divide_by_zero(divide_by_zero)
	);

endmodule

### design/gfpa_ctrl.sv
// ---------------------------------------------------------------------------
// gfpa_ctrl: sequencer for the GF(2) polynomial ALU
// Accepts one word at a time, steps the datapath, holds the result word.
// ---------------------------------------------------------------------------
module gfpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	output logic              out_valid,
	input  logic              out_stall,
	output gfpa_pkg::dp_cmd_t dcmd,
	input  gfpa_pkg::dp_stat_t dstat
);

	gfpa_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gfpa_pkg::ST_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		dcmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			gfpa_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					dcmd.load = 1'b1;
					unique case (gfpa_pkg::op_t'(cmd))
						gfpa_pkg::OP_ADD: state_nx = gfpa_pkg::ST_DONE;
						gfpa_pkg::OP_MUL: state_nx = gfpa_pkg::ST_MUL;
						default: state_nx = gfpa_pkg::ST_EU;
					endcase
				end
			end
			gfpa_pkg::ST_MUL: begin
				dcmd.mul_step = 1'b1;
				if (dstat.mul_last) state_nx = gfpa_pkg::ST_DONE;
			end
			gfpa_pkg::ST_EU: begin
				if (dstat.eu_done) state_nx = gfpa_pkg::ST_DONE;
				else dcmd.eu_step = 1'b1;
			end
			gfpa_pkg::ST_DONE: begin
				out_valid = 1'b1;
				if (!out_stall) state_nx = gfpa_pkg::ST_IDLE;
			end
			default: state_nx = gfpa_pkg::ST_IDLE;
		endcase
	end

endmodule

### design/gfpa_dp.sv
// ---------------------------------------------------------------------------
// gfpa_dp: datapath for the GF(2) polynomial ALU
// Shift-XOR multiplier and a one-step-per-cycle Euclid/division engine.
// ---------------------------------------------------------------------------
module gfpa_dp #(
	parameter int MAX_DEG = gfpa_pkg::MAX_DEG_DEF
) (
	input  logic               clk,
	input  logic [1:0]         cmd,
	input  logic [31:0]        operand_x,
	input  logic [31:0]        operand_y,
	input  gfpa_pkg::dp_cmd_t  dcmd,
	output gfpa_pkg::dp_stat_t dstat,
	output logic [62:0]        primary,
	output logic [31:0]        secondary,
	output logic [31:0]        gcd_value,
	output logic               divide_by_zero
);

	localparam logic [31:0] OPER_MASK = 32'((64'd1 << (MAX_DEG + 1)) - 64'd1);
	localparam logic signed [5:0] DEG_START = 6'(MAX_DEG);

	gfpa_pkg::op_t op_q;
	logic [31:0] r0_q, r1_q, s0_q, s1_q, t0_q, t1_q;
	logic [62:0] acc_q;
	logic signed [5:0] d0_q, d1_q;
	logic [4:0] cnt_q;
	logic dz_q;

	logic [31:0] xm, ym;
	logic p0, p1, ge;
	logic [4:0] sh;

	assign xm = operand_x & OPER_MASK;
	assign ym = operand_y & OPER_MASK;

	// a degree is settled once its top bit is set or the value is zero
	assign p0 = d0_q[5] || r0_q[d0_q[4:0]];
	assign p1 = d1_q[5] || r1_q[d1_q[4:0]];
	assign ge = !d1_q[5] && (d0_q >= d1_q);
	assign sh = 5'(d0_q - d1_q);

	always_comb begin
		dstat.mul_last = (cnt_q == 5'd31);
		if (op_q == gfpa_pkg::OP_DIV) dstat.eu_done = p0 && p1 && !ge;
		else dstat.eu_done = p0 && p1 && d1_q[5];
	end

	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			op_q <= gfpa_pkg::op_t'(cmd);
			if (gfpa_pkg::op_t'(cmd) == gfpa_pkg::OP_GCD) begin
				r0_q <= ym;
				r1_q <= xm;
			end else begin
				r0_q <= xm;
				r1_q <= ym;
			end
			s0_q <= 32'd1;
			t0_q <= 32'd0;
			s1_q <= 32'd0;
			t1_q <= 32'd1;
			d0_q <= DEG_START;
			d1_q <= DEG_START;
			cnt_q <= '0;
			acc_q <= (gfpa_pkg::op_t'(cmd) == gfpa_pkg::OP_ADD) ? {31'd0, xm ^ ym} : '0;
			dz_q <= (gfpa_pkg::op_t'(cmd) == gfpa_pkg::OP_DIV) && (ym == 32'd0);
		end else if (dcmd.mul_step) begin
			// MSB-first: acc = acc*x + (top bit of y)*x_operand
			acc_q <= {acc_q[61:0], 1'b0} ^ (r1_q[31] ? {31'd0, r0_q} : 63'd0);
			r1_q <= {r1_q[30:0], 1'b0};
			cnt_q <= cnt_q + 5'd1;
		end else if (dcmd.eu_step) begin
			if (!p0) begin
				d0_q <= d0_q - 6'sd1;
			end else if (!p1) begin
				d1_q <= d1_q - 6'sd1;
			end else if (ge) begin
				r0_q <= r0_q ^ (r1_q << sh);
				s0_q <= s0_q ^ (s1_q << sh);
				t0_q <= t0_q ^ (t1_q << sh);
				acc_q <= acc_q ^ (63'd1 << sh);
			end else begin
				r0_q <= r1_q;
				r1_q <= r0_q;
				s0_q <= s1_q;
				s1_q <= s0_q;
				t0_q <= t1_q;
				t1_q <= t0_q;
				d0_q <= d1_q;
				d1_q <= d0_q;
			end
		end
	end

	always_comb begin
		primary = acc_q;
		secondary = '0;
		gcd_value = '0;
		case (op_q)
			gfpa_pkg::OP_DIV: secondary = r0_q;
			gfpa_pkg::OP_GCD: begin
				primary = {31'd0, t0_q};
				secondary = s0_q;
				gcd_value = r0_q;
			end
			default: ;
		endcase
	end
	assign divide_by_zero = dz_q;

endmodule

### design/gfpa_checker.sv
// ---------------------------------------------------------------------------
// gfpa_checker: port-level checks for the GF(2) polynomial ALU
// One word in flight at a time; result word fields stay consistent.
// ---------------------------------------------------------------------------
module gfpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [62:0] primary,
	input logic [31:0] secondary,
	input logic [31:0] gcd_value,
	input logic        divide_by_zero
);

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (in_stall && !out_valid) || out_valid)
		else $error("accepting again right after accept");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid) else $error("result repeated");

	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && divide_by_zero) |-> (primary == 63'd0 && gcd_value == 32'd0))
		else $error("zero divisor result malformed");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(primary) && $stable(secondary))
		else $error("stalled result changed");

endmodule

bind gf2_polynomial_alu_core gfpa_checker u_gfpa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .primary(primary),
	.secondary(secondary), .gcd_value(gcd_value), .divide_by_zero(divide_by_zero)
);

### sim/gf2_polynomial_alu_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gf2_polynomial_alu_core_tb: self-checking bench for the GF(2) polynomial ALU
// Drives add, multiply, divide and extended-gcd words with random gaps and
// output stalls, predicts every result and checks it against the block.
// ---------------------------------------------------------------------------

typedef struct {
	logic [62:0] prim;
	logic [31:0] sec;
	logic [31:0] gcd;
	logic        dz;
} poly_result_t;

class poly_scoreboard;
	poly_result_t pending[$];
	int errors;
	int checked;
	int op_seen[4];

	function automatic int degree(logic [63:0] p);
		int d;
		d = -1;
		for (int i = 0; i < 64; i++)
			if (p[i]) d = i;
		return d;
	endfunction

	function automatic logic [63:0] clmul(logic [63:0] a, logic [63:0] b);
		logic [63:0] acc;
		acc = '0;
		a = a & 64'hFFFF_FFFF;
		b = b & 64'hFFFF_FFFF;
		for (int i = 0; i < 32; i++)
			if (b[i]) acc = acc ^ (a << i);
		return acc;
	endfunction

	function automatic void long_div(logic [63:0] num, logic [63:0] den,
			output logic [63:0] q, output logic [63:0] r);
		int dd;
		int dr;
		dd = degree(den);
		q = '0;
		r = num;
		dr = degree(r);
		while (dr >= dd && dd >= 0) begin
			q[dr - dd] = ~q[dr - dd];
			r = r ^ (den << (dr - dd));
			dr = degree(r);
		end
	endfunction

	function void note_word(gfpa_pkg::op_t op, logic [31:0] xin, logic [31:0] yin);
		poly_result_t e;
		logic [63:0] x, y, q, r;
		logic [63:0] r0, s0, t0, r1, s1, t1, r2, s2, t2;
		x = {32'd0, xin};
		y = {32'd0, yin};
		e.prim = '0; e.sec = '0; e.gcd = '0; e.dz = 1'b0;
		op_seen[op]++;
		case (op)
			gfpa_pkg::OP_ADD: e.prim = 63'(x ^ y);
			gfpa_pkg::OP_MUL: e.prim = 63'(clmul(x, y));
			gfpa_pkg::OP_DIV: begin
				if (y == 0) begin
					e.dz = 1'b1;
					e.sec = xin;
				end else begin
					long_div(x, y, q, r);
					e.prim = 63'(q);
					e.sec = 32'(r);
				end
			end
			default: begin
				// remainder sequence starts from (y, x)
				r0 = y; s0 = 64'd1; t0 = 64'd0;
				r1 = x; s1 = 64'd0; t1 = 64'd1;
				for (int g = 0; g < 70 && r1 != 0; g++) begin
					long_div(r0, r1, q, r2);
					s2 = (s0 ^ clmul(q, s1)) & 64'hFFFF_FFFF;
					t2 = (t0 ^ clmul(q, t1)) & 64'hFFFF_FFFF;
					r0 = r1; s0 = s1; t0 = t1;
					r1 = r2; s1 = s2; t1 = t2;
				end
				e.gcd = 32'(r0);
				e.prim = 63'(t0);
				e.sec = 32'(s0);
			end
		endcase
		pending.insert(pending.size(), e);
	endfunction

	function void check_word(logic [62:0] p, logic [31:0] s, logic [31:0] g, logic dz);
		poly_result_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result word primary=%h", $time, p);
			errors++;
			return;
		end
		e = pending.pop_front();
		checked++;
		if (p !== e.prim) begin
			$display("%0t: primary expected %h actual %h", $time, e.prim, p);
			errors++;
		end
		if (s !== e.sec) begin
			$display("%0t: secondary expected %h actual %h", $time, e.sec, s);
			errors++;
		end
		if (g !== e.gcd) begin
			$display("%0t: gcd_value expected %h actual %h", $time, e.gcd, g);
			errors++;
		end
		if (dz !== e.dz) begin
			$display("%0t: divide_by_zero expected %b actual %b", $time, e.dz, dz);
			errors++;
		end
	endfunction
endclass

module gf2_polynomial_alu_core_tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = '0;
	logic [31:0] operand_x = '0;
	logic [31:0] operand_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [62:0] primary;
	logic [31:0] secondary;
	logic [31:0] gcd_value;
	logic divide_by_zero;

	poly_scoreboard sb = new();
	bit quiet = 1'b0;      // no idling in the last part
	int hold_off = 0;      // long receiver stall request, in cycles

	gf2_polynomial_alu_core uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(primary, secondary, gcd_value, divide_by_zero);
	end

	// receiver: random stall bursts, plus long hold-offs on request
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_stall <= 1'b1;
				n = hold_off;
				hold_off = 0;
				repeat (n - 1) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(0, 11)) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic [31:0] rand_poly();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'(1) << $urandom_range(0, 31);
			2: return $urandom() >> $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_word(gfpa_pkg::op_t op, logic [31:0] x, logic [31:0] y);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		operand_x <= x;
		operand_y <= y;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_word(op, x, y);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	initial begin
		gfpa_pkg::op_t op;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: field extremes, every command, zero divisor, gcd with zeros
		send_word(gfpa_pkg::OP_ADD, 32'h0, 32'h0);
		send_word(gfpa_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h5555_AAAA);
		send_word(gfpa_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(gfpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
		send_word(gfpa_pkg::OP_MUL, 32'h0, 32'h1234_5678);
		send_word(gfpa_pkg::OP_DIV, 32'hDEAD_BEEF, 32'h0);
		send_word(gfpa_pkg::OP_DIV, 32'h0, 32'h0);
		send_word(gfpa_pkg::OP_DIV, 32'hFFFF_FFFF, 32'h1);
		send_word(gfpa_pkg::OP_DIV, 32'h1234_5678, 32'h8000_0000);
		send_word(gfpa_pkg::OP_DIV, 32'h3, 32'hFFFF_FFFF);
		send_word(gfpa_pkg::OP_GCD, 32'h0, 32'h0);
		send_word(gfpa_pkg::OP_GCD, 32'h0, 32'hABCD_0123);
		send_word(gfpa_pkg::OP_GCD, 32'h8765_4321, 32'h0);
		send_word(gfpa_pkg::OP_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(gfpa_pkg::OP_GCD, 32'h8000_0000, 32'h1);
		send_word(gfpa_pkg::OP_GCD, 32'h1, 32'h8000_0000);
		send_word(gfpa_pkg::OP_GCD, 32'hFFFF_FFFE, 32'h7FFF_FFFF);

		// sender pause until every result is back
		drain();

		// receiver holds off while words keep coming
		hold_off = 300;
		for (int i = 0; i < 6; i++) send_word(gfpa_pkg::OP_MUL, $urandom(), $urandom());

		for (int i = 0; i < 650; i++) begin
			if (i == 560) quiet = 1'b1;
			op = gfpa_pkg::op_t'($urandom_range(0, 3));
			send_word(op, rand_poly(), rand_poly());
		end
		drain();
		repeat (200) @(negedge clk);

		$display("Checked %0d result words: add %0d, mul %0d, div %0d, gcd %0d.",
			sb.checked, sb.op_seen[0], sb.op_seen[1], sb.op_seen[2], sb.op_seen[3]);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS gf2_polynomial_alu_core");
		else
			$display("FAIL gf2_polynomial_alu_core");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL gf2_polynomial_alu_core");
		$finish;
	end
endmodule
